### rtl/crpe_pkg.sv
package crpe_pkg;

  // Field widths
  localparam int PT_W  = 16;               // control point coordinate, signed Q12.4
  localparam int T_W   = 17;               // curve parameter, unsigned Q1.16
  localparam int OUT_W = 17;               // result coordinate, signed Q13.4

  // Stream payload widths, rounded up to whole bytes
  localparam int S_DATA_W = 152;
  localparam int M_DATA_W = 40;

  // Register stages from input transfer to output register
  localparam int NUM_STAGES = 5;

  // Datapath widths
  localparam int CO_W  = 20;               // b, c, d polynomial coefficients
  localparam int TS_W  = T_W + 1;          // t as a signed multiplier operand
  localparam int M1_W  = 38;               // d*T + c*2^16
  localparam int M2_W  = 54;               // (d*T + c*2^16)*T + b*2^32
  localparam int SPLIT = 27;               // low/high split of the last product
  localparam int PH_W  = M2_W - SPLIT + TS_W;
  localparam int PL_W  = SPLIT + T_W;
  localparam int SUM_W = 72;
  localparam int RES_SHIFT  = 49;          // raw sum is scaled by 2^49
  localparam int HALF_SHIFT = RES_SHIFT - 1;
  localparam int Q_W   = SUM_W - RES_SHIFT;

  localparam logic [T_W-1:0] T_ONE = 17'h10000;

endpackage

### rtl/crpe_ctrl.sv
module crpe_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [crpe_pkg::NUM_STAGES-1:0]     stage_en
);
  import crpe_pkg::*;

  logic [NUM_STAGES-1:0] valid;
  logic [NUM_STAGES-1:0] valid_next;
  logic [NUM_STAGES-1:0] shift_in;
  logic [NUM_STAGES:0]   rdy;

  // A stage may load when it is empty or its successor loads in the same cycle.
  always_comb begin
    rdy[NUM_STAGES] = out_ready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !valid[k] || rdy[k+1];
    end
  end

  assign shift_in = {valid[NUM_STAGES-2:0], in_valid};

  always_comb begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      valid_next[k] = rdy[k] ? shift_in[k] : valid[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

  assign stage_en  = rdy[NUM_STAGES-1:0];
  assign in_ready  = rdy[0];
  assign out_valid = valid[NUM_STAGES-1];

  // An empty output register never blocks the input side.
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !valid[NUM_STAGES-1] |-> in_ready)
    else $error("input stalled while output register is empty");

  // Items in flight change only by transfers on the two sides.
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> $countones(valid) == $countones($past(valid))
      + ($past(in_valid && in_ready) ? 1 : 0)
      - ($past(out_valid && out_ready) ? 1 : 0))
    else $error("pipeline occupancy lost or duplicated an item");

  // A full pipeline with a stalled output takes nothing.
  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (&valid) && !out_ready |-> !in_ready)
    else $error("full pipeline accepted an item under stall");

endmodule

### rtl/crpe_axis.sv
module crpe_axis (
  input  logic                                   clk,
  input  logic [crpe_pkg::NUM_STAGES-1:0]        stage_en,
  input  logic signed [crpe_pkg::PT_W-1:0]       a0,
  input  logic signed [crpe_pkg::PT_W-1:0]       a1,
  input  logic signed [crpe_pkg::PT_W-1:0]       a2,
  input  logic signed [crpe_pkg::PT_W-1:0]       a3,
  input  logic [crpe_pkg::T_W-1:0]               param_t,
  output logic signed [crpe_pkg::OUT_W-1:0]      point
);
  import crpe_pkg::*;

  // Stage 0: coefficients and clamped t
  logic signed [CO_W-1:0] e_diff;
  logic signed [CO_W-1:0] b_next, c_next, d_next;
  logic [T_W-1:0]         t_next;
  logic signed [PT_W-1:0] a1_0;
  logic signed [CO_W-1:0] b_0, c_0, d_0;
  logic [T_W-1:0]         t_0;

  always_comb begin
    e_diff = CO_W'(a1) - CO_W'(a2);
    b_next = CO_W'(a2) - CO_W'(a0);
    c_next = (CO_W'(a0) <<< 1) - (CO_W'(a1) <<< 2) - CO_W'(a1)
           + (CO_W'(a2) <<< 2) - CO_W'(a3);
    d_next = (e_diff <<< 1) + e_diff + CO_W'(a3) - CO_W'(a0);
    t_next = (param_t > T_ONE) ? T_ONE : param_t;
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      a1_0 <= a1;
      b_0  <= b_next;
      c_0  <= c_next;
      d_0  <= d_next;
      t_0  <= t_next;
    end
  end

  // Stage 1: m1 = d*T + c*2^16
  logic signed [TS_W-1:0] ts_0;
  logic signed [M1_W-1:0] m1_next;
  logic signed [M1_W-1:0] m1_1;
  logic signed [PT_W-1:0] a1_1;
  logic signed [CO_W-1:0] b_1;
  logic [T_W-1:0]         t_1;

  assign ts_0    = $signed({1'b0, t_0});
  assign m1_next = M1_W'(d_0) * M1_W'(ts_0) + (M1_W'(c_0) <<< 16);

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      m1_1 <= m1_next;
      a1_1 <= a1_0;
      b_1  <= b_0;
      t_1  <= t_0;
    end
  end

  // Stage 2: m2 = m1*T + b*2^32
  logic signed [TS_W-1:0] ts_1;
  logic signed [M2_W-1:0] m2_next;
  logic signed [M2_W-1:0] m2_2;
  logic signed [PT_W-1:0] a1_2;
  logic [T_W-1:0]         t_2;

  assign ts_1    = $signed({1'b0, t_1});
  assign m2_next = M2_W'(m1_1) * M2_W'(ts_1) + (M2_W'(b_1) <<< 32);

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      m2_2 <= m2_next;
      a1_2 <= a1_1;
      t_2  <= t_1;
    end
  end

  // Stage 3: m2*T as two partial products
  logic signed [TS_W-1:0]        ts_2;
  logic signed [M2_W-SPLIT-1:0]  m2_hi;
  logic signed [PH_W-1:0]        pp_hi_next;
  logic [PL_W-1:0]               pp_lo_next;
  logic signed [PH_W-1:0]        pp_hi_3;
  logic [PL_W-1:0]               pp_lo_3;
  logic signed [PT_W-1:0]        a1_3;

  assign ts_2       = $signed({1'b0, t_2});
  assign m2_hi      = $signed(m2_2[M2_W-1:SPLIT]);
  assign pp_hi_next = PH_W'(m2_hi) * PH_W'(ts_2);
  assign pp_lo_next = PL_W'(m2_2[SPLIT-1:0]) * PL_W'(t_2);

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      pp_hi_3 <= pp_hi_next;
      pp_lo_3 <= pp_lo_next;
      a1_3    <= a1_2;
    end
  end

  // Stage 4: add a1*2^49 and the half, floor by 2^49, saturate
  logic signed [SUM_W-1:0] sum;
  logic signed [Q_W-1:0]   q;
  logic signed [OUT_W-1:0] point_next;

  always_comb begin
    sum = (SUM_W'(pp_hi_3) <<< SPLIT) + $signed(SUM_W'(pp_lo_3))
        + (SUM_W'(a1_3) <<< RES_SHIFT) + (SUM_W'(1) <<< HALF_SHIFT);
    q   = sum[SUM_W-1:RES_SHIFT];
    if (q[Q_W-1:OUT_W-1] == '0 || q[Q_W-1:OUT_W-1] == '1) begin
      point_next = q[OUT_W-1:0];
    end else if (q[Q_W-1]) begin
      point_next = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      point_next = {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      point <= point_next;
    end
  end

endmodule

### rtl/catmull_rom_point_eval_unit.sv
// Channel  Dir  Payload (lowest bit first)                              Handshake
// s_*      in   p0_x p0_y p1_x p1_y p2_x p2_y p3_x p3_y param_t, pad     s_tvalid/s_tready
// m_*      out  point_x point_y, pad                                    m_tvalid/m_tready
//
// One point per cycle sustained while m_tready stays high; each transfer runs
// through the five register stages of the Horner evaluation, the last being the
// output register (coefficients, d*T+c, *T+b, split product, round and saturate).
// Reset clears only the stage valid bits; the datapath registers hold no reset.
// A stall at m_tready holds a full output register and the unbroken run of full
// stages behind it; the rest keep filling: up to five in flight, none dropped or repeated.
module catmull_rom_point_eval_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // p0_x[15:0] p0_y[31:16] p1_x[47:32] p1_y[63:48] p2_x[79:64] p2_y[95:80]
  // p3_x[111:96] p3_y[127:112] param_t[144:128], zero pad to 152 bits
  input  logic [crpe_pkg::S_DATA_W-1:0]       s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // point_x[16:0] point_y[33:17], zero pad to 40 bits
  output logic [crpe_pkg::M_DATA_W-1:0]       m_tdata
);
  import crpe_pkg::*;

  logic [NUM_STAGES-1:0]   stage_en;
  logic signed [OUT_W-1:0] point_x;
  logic signed [OUT_W-1:0] point_y;
  logic [T_W-1:0]          param_t;

  assign param_t = s_tdata[8*PT_W +: T_W];

  // Valid bits and the ready chain shared by both axis lanes
  crpe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stage_en  (stage_en)
  );

  // X lane takes the even coordinates of the packed control points
  crpe_axis u_axis_x (
    .clk      (clk),
    .stage_en (stage_en),
    .a0       ($signed(s_tdata[0*PT_W +: PT_W])),
    .a1       ($signed(s_tdata[2*PT_W +: PT_W])),
    .a2       ($signed(s_tdata[4*PT_W +: PT_W])),
    .a3       ($signed(s_tdata[6*PT_W +: PT_W])),
    .param_t  (param_t),
    .point    (point_x)
  );

  // Y lane takes the odd coordinates
  crpe_axis u_axis_y (
    .clk      (clk),
    .stage_en (stage_en),
    .a0       ($signed(s_tdata[1*PT_W +: PT_W])),
    .a1       ($signed(s_tdata[3*PT_W +: PT_W])),
    .a2       ($signed(s_tdata[5*PT_W +: PT_W])),
    .a3       ($signed(s_tdata[7*PT_W +: PT_W])),
    .param_t  (param_t),
    .point    (point_y)
  );

  assign m_tdata = {{(M_DATA_W-2*OUT_W){1'b0}}, point_y, point_x};

endmodule
